### hw/rtl/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types, widths, reset values and codes for the ABS slip controller.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int NUM_WHEELS = 4;
    localparam int SPEED_BITS = 16;
    localparam int THR_BITS   = 8;
    localparam int SLIP_BITS  = SPEED_BITS + THR_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [SPEED_BITS-1:0] t_speed;
    typedef logic [THR_BITS-1:0]   t_thr;
    typedef logic [SLIP_BITS-1:0]  t_slip;

    typedef enum logic [1:0] {
        CMD_APPLY   = 2'd0,
        CMD_HOLD    = 2'd1,
        CMD_RELEASE = 2'd2
    } t_brake_cmd;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_THR = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_THR  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REF_DROP = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SPD  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_REF = 3'd4;

    // Reset values
    localparam t_thr   RST_HIGH_THR = 8'd51;
    localparam t_thr   RST_LOW_THR  = 8'd26;
    localparam t_speed RST_REF_DROP = 16'd23;
    localparam t_speed RST_MIN_SPD  = 16'd256;
    localparam t_speed RST_REF      = 16'd0;

    // Control into the reference tracker
    typedef struct packed {
        logic   advance;
        logic   load;
        t_speed load_value;
    } t_trk_ctrl;

endpackage

### hw/rtl/asc_ref_tracker.sv
// ----------------------------------------------------------------------------
// asc_ref_tracker
// Peak-hold reference speed: fastest wheel against the decayed old reference.
// ----------------------------------------------------------------------------
module asc_ref_tracker
    import asc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_trk_ctrl               i_ctrl,
    input  t_speed [NUM_WHEELS-1:0] i_wheel,
    input  t_speed                  i_drop,
    input  t_speed                  i_min_speed,
    output t_speed                  o_new_ref,
    output logic                    o_active
);

    t_speed r_ref;
    t_speed w_peak;
    t_speed w_carried;

    always_comb begin
        w_peak = '0;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            if (i_wheel[i] > w_peak) begin
                w_peak = i_wheel[i];
            end
        end
    end

    // Saturate the decay at zero
    assign w_carried = (r_ref > i_drop) ? (r_ref - i_drop) : '0;
    assign o_new_ref = (w_peak > w_carried) ? w_peak : w_carried;
    assign o_active  = (o_new_ref >= i_min_speed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= RST_REF;
        end else if (i_ctrl.load) begin
            r_ref <= i_ctrl.load_value;
        end else if (i_ctrl.advance) begin
            r_ref <= o_new_ref;
        end
    end

endmodule

### hw/rtl/asc_slip_lane.sv
// ----------------------------------------------------------------------------
// asc_slip_lane
// Per-wheel slip classifier: cross-multiplied threshold tests, no division.
// ----------------------------------------------------------------------------
module asc_slip_lane
    import asc_pkg::*;
(
    input  t_speed     i_ref,
    input  t_speed     i_wheel,
    input  logic       i_active,
    input  t_thr       i_high_thr,
    input  t_thr       i_low_thr,
    output t_brake_cmd o_cmd
);

    t_slip w_diff;
    t_slip w_high_lim;
    t_slip w_low_lim;

    // Reference is never below any wheel of the same item
    assign w_diff     = {i_ref - i_wheel, {THR_BITS{1'b0}}};
    assign w_high_lim = SLIP_BITS'(i_high_thr) * SLIP_BITS'(i_ref);
    assign w_low_lim  = SLIP_BITS'(i_low_thr) * SLIP_BITS'(i_ref);

    always_comb begin
        priority if (!i_active) begin
            o_cmd = CMD_HOLD;
        end else if (w_diff > w_high_lim) begin
            o_cmd = CMD_RELEASE;
        end else if (w_diff < w_low_lim) begin
            o_cmd = CMD_APPLY;
        end else begin
            o_cmd = CMD_HOLD;
        end
    end

endmodule

### hw/rtl/asc_result_merge.sv
// ----------------------------------------------------------------------------
// asc_result_merge
// Combine lane commands into one result and hold it in the output register.
// ----------------------------------------------------------------------------
module asc_result_merge
    import asc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_load,
    input  t_speed                      i_ref,
    input  logic                        i_active,
    input  t_brake_cmd [NUM_WHEELS-1:0] i_cmd,
    output t_speed                      o_ref,
    output logic                        o_active,
    output t_brake_cmd [NUM_WHEELS-1:0] o_cmd,
    output logic                        o_any_release
);

    t_speed                      r_ref;
    logic                        r_active;
    t_brake_cmd [NUM_WHEELS-1:0] r_cmd;
    logic                        r_any_release;
    logic                        n_any_release;

    always_comb begin
        n_any_release = 1'b0;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            n_any_release = n_any_release | (i_cmd[i] == CMD_RELEASE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ref         <= i_ref;
            r_active      <= i_active;
            r_cmd         <= i_cmd;
            r_any_release <= n_any_release;
        end
    end

    assign o_ref         = r_ref;
    assign o_active      = r_active;
    assign o_cmd         = r_cmd;
    assign o_any_release = r_any_release;

endmodule

### hw/rtl/abs_slip_controller.sv
// ----------------------------------------------------------------------------
// abs_slip_controller
// ABS wheel-slip controller with a peak-hold reference speed.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries four wheel speeds, Q8.8 m/s.
//   A transaction completes when i_valid is high and o_stall is low.
//   Output channel (o_valid / i_stall) carries the updated reference speed,
//   the control-active flag, one command per wheel and the any-release flag.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes one register by
//   index; o_cfg_ready is always high. Writing the initial reference index
//   loads the reference state directly. Write configuration only when idle.
//   A result is registered in stage one, then in the output register.
//   Throughput: one transaction per cycle unless the receiver stalls; the
//   reference update (peak of the wheels against the decayed old reference)
//   is combinational; the four slip lanes then work in parallel in stage two.
//   Reset: reference clears to zero, thresholds return to defaults, both
//   pipeline stages empty.
//   Stall: a waiting result holds in the output register while one more
//   transaction is taken into the first stage; o_stall rises only when
//   both stages are full and the receiver still stalls.
// ----------------------------------------------------------------------------
module abs_slip_controller
    import asc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [SPEED_BITS-1:0]    i_wheel_speed_0,
    input  logic [SPEED_BITS-1:0]    i_wheel_speed_1,
    input  logic [SPEED_BITS-1:0]    i_wheel_speed_2,
    input  logic [SPEED_BITS-1:0]    i_wheel_speed_3,
    // output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [SPEED_BITS-1:0]    o_reference_speed_out,
    output logic                     o_control_active,
    output logic [1:0]               o_brake_cmd_0,
    output logic [1:0]               o_brake_cmd_1,
    output logic [1:0]               o_brake_cmd_2,
    output logic [1:0]               o_brake_cmd_3,
    output logic                     o_any_release
);

    // Configuration registers
    t_thr   r_high_thr;
    t_thr   r_low_thr;
    t_speed r_ref_drop;
    t_speed r_min_speed;
    logic   w_cfg_write;

    // Handshake control
    logic   r_s1_valid;
    logic   r_out_valid;
    logic   w_out_free;
    logic   w_s1_move;
    logic   w_in_accept;

    // Stage one payload
    t_speed [NUM_WHEELS-1:0] w_wheel;
    t_speed [NUM_WHEELS-1:0] r_s1_wheel;
    t_speed                  r_s1_ref;
    logic                    r_s1_active;

    t_trk_ctrl               w_trk_ctrl;
    t_speed                  w_new_ref;
    logic                    w_new_active;

    t_brake_cmd [NUM_WHEELS-1:0] w_lane_cmd;
    t_brake_cmd [NUM_WHEELS-1:0] w_out_cmd;

    assign w_wheel[0] = i_wheel_speed_0;
    assign w_wheel[1] = i_wheel_speed_1;
    assign w_wheel[2] = i_wheel_speed_2;
    assign w_wheel[3] = i_wheel_speed_3;

    // Configuration: always ready, unknown indexes drop silently
    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thr  <= RST_HIGH_THR;
            r_low_thr   <= RST_LOW_THR;
            r_ref_drop  <= RST_REF_DROP;
            r_min_speed <= RST_MIN_SPD;
        end else if (w_cfg_write) begin
            unique case (i_cfg_index)
                CFG_HIGH_THR: r_high_thr  <= i_cfg_data[THR_BITS-1:0];
                CFG_LOW_THR:  r_low_thr   <= i_cfg_data[THR_BITS-1:0];
                CFG_REF_DROP: r_ref_drop  <= i_cfg_data[SPEED_BITS-1:0];
                CFG_MIN_SPD:  r_min_speed <= i_cfg_data[SPEED_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Advance the output register when it is empty or being taken; advance
    // stage one into it; take a new transaction whenever stage one frees up.
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_s1_move   = r_s1_valid && w_out_free;
    assign o_stall     = r_s1_valid && !w_out_free;
    assign w_in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Reference tracker: state advances on each input transaction
    assign w_trk_ctrl.advance    = w_in_accept;
    assign w_trk_ctrl.load       = w_cfg_write && (i_cfg_index == CFG_INIT_REF);
    assign w_trk_ctrl.load_value = i_cfg_data[SPEED_BITS-1:0];

    asc_ref_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_trk_ctrl),
        .i_wheel     (w_wheel),
        .i_drop      (r_ref_drop),
        .i_min_speed (r_min_speed),
        .o_new_ref   (w_new_ref),
        .o_active    (w_new_active)
    );

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_wheel  <= w_wheel;
            r_s1_ref    <= w_new_ref;
            r_s1_active <= w_new_active;
        end
    end

    // One slip lane per wheel
    for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_lane
        asc_slip_lane u_lane (
            .i_ref      (r_s1_ref),
            .i_wheel    (r_s1_wheel[g]),
            .i_active   (r_s1_active),
            .i_high_thr (r_high_thr),
            .i_low_thr  (r_low_thr),
            .o_cmd      (w_lane_cmd[g])
        );
    end

    asc_result_merge u_merge (
        .i_clk         (i_clk),
        .i_load        (w_s1_move),
        .i_ref         (r_s1_ref),
        .i_active      (r_s1_active),
        .i_cmd         (w_lane_cmd),
        .o_ref         (o_reference_speed_out),
        .o_active      (o_control_active),
        .o_cmd         (w_out_cmd),
        .o_any_release (o_any_release)
    );

    assign o_valid       = r_out_valid;
    assign o_brake_cmd_0 = w_out_cmd[0];
    assign o_brake_cmd_1 = w_out_cmd[1];
    assign o_brake_cmd_2 = w_out_cmd[2];
    assign o_brake_cmd_3 = w_out_cmd[3];

endmodule

### bench/asc_checker.sv
// ----------------------------------------------------------------------------
// asc_checker
// Watches the configuration, wheel-speed and result channels of the ABS slip
// controller, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module asc_checker
    import asc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  t_speed                   i_wheel_speed_0,
    input  t_speed                   i_wheel_speed_1,
    input  t_speed                   i_wheel_speed_2,
    input  t_speed                   i_wheel_speed_3,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  t_speed                   i_reference_speed_out,
    input  logic                     i_control_active,
    input  logic [1:0]               i_brake_cmd_0,
    input  logic [1:0]               i_brake_cmd_1,
    input  logic [1:0]               i_brake_cmd_2,
    input  logic [1:0]               i_brake_cmd_3,
    input  logic                     i_any_release,
    output int                       o_errors,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_speed                       ref_speed;
        logic                         active;
        logic [NUM_WHEELS-1:0][1:0]   cmd;
        logic                         any_rel;
    } t_slip_verdict;

    t_thr          release_thr = RST_HIGH_THR;
    t_thr          apply_thr   = RST_LOW_THR;
    t_speed        drop_step   = RST_REF_DROP;
    t_speed        min_speed   = RST_MIN_SPD;
    t_speed        ref_track   = RST_REF;
    t_slip_verdict verdict_q[$];
    int            mismatch_count = 0;

    function automatic t_slip_verdict judge_wheels(input t_speed w0, w1, w2, w3);
        t_speed        wheels[NUM_WHEELS];
        t_speed        peak;
        t_speed        decayed;
        logic [31:0]   slip_scaled;
        t_slip_verdict v;
        int            i;
        wheels[0] = w0;
        wheels[1] = w1;
        wheels[2] = w2;
        wheels[3] = w3;
        peak = '0;
        for (i = 0; i < NUM_WHEELS; i++) begin
            if (wheels[i] > peak) peak = wheels[i];
        end
        decayed     = (ref_track > drop_step) ? t_speed'(ref_track - drop_step) : '0;
        v.ref_speed = (peak > decayed) ? peak : decayed;
        v.active    = (v.ref_speed >= min_speed);
        v.any_rel   = 1'b0;
        for (i = 0; i < NUM_WHEELS; i++) begin
            v.cmd[i] = CMD_HOLD;
            if (v.active) begin
                // reference never sits below a wheel, so the gap is non-negative
                slip_scaled = 32'(t_speed'(v.ref_speed - wheels[i])) << 8;
                if (slip_scaled > 32'(release_thr) * 32'(v.ref_speed)) begin
                    v.cmd[i]  = CMD_RELEASE;
                    v.any_rel = 1'b1;
                end else if (slip_scaled < 32'(apply_thr) * 32'(v.ref_speed)) begin
                    v.cmd[i] = CMD_APPLY;
                end
            end
        end
        return v;
    endfunction

    task automatic compare_field(input string field, input logic [15:0] want, got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_slip_verdict want;
        if (!i_rst_n) begin
            release_thr = RST_HIGH_THR;
            apply_thr   = RST_LOW_THR;
            drop_step   = RST_REF_DROP;
            min_speed   = RST_MIN_SPD;
            ref_track   = RST_REF;
            verdict_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HIGH_THR: release_thr = i_cfg_data[THR_BITS-1:0];
                    CFG_LOW_THR:  apply_thr   = i_cfg_data[THR_BITS-1:0];
                    CFG_REF_DROP: drop_step   = i_cfg_data;
                    CFG_MIN_SPD:  min_speed   = i_cfg_data;
                    CFG_INIT_REF: ref_track   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with nothing expected, expected none, actual ref %0h",
                             $time, i_reference_speed_out);
                end else begin
                    want = verdict_q.pop_front();
                    compare_field("reference_speed_out", want.ref_speed, i_reference_speed_out);
                    compare_field("control_active", 16'(want.active), 16'(i_control_active));
                    compare_field("brake_cmd_0", 16'(want.cmd[0]), 16'(i_brake_cmd_0));
                    compare_field("brake_cmd_1", 16'(want.cmd[1]), 16'(i_brake_cmd_1));
                    compare_field("brake_cmd_2", 16'(want.cmd[2]), 16'(i_brake_cmd_2));
                    compare_field("brake_cmd_3", 16'(want.cmd[3]), 16'(i_brake_cmd_3));
                    compare_field("any_release", 16'(want.any_rel), 16'(i_any_release));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want      = judge_wheels(i_wheel_speed_0, i_wheel_speed_1,
                                         i_wheel_speed_2, i_wheel_speed_3);
                ref_track = want.ref_speed;
                verdict_q.push_back(want);
            end
        end
        o_errors  <= mismatch_count;
        o_pending <= verdict_q.size();
    end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the ABS slip controller bench: drives configuration writes and
// wheel-speed transactions, applies random idling on both sides and reports
// the verdict handed back by the checker.
// ----------------------------------------------------------------------------
module tb;
    import asc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any transaction before the run is declared hung
    localparam int QUIET_LIMIT   = 4000;
    // Pipeline is two stages deep; allow a little slack after draining
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_ITEMS   = 94;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    t_speed                   i_wheel_speed_0 = '0;
    t_speed                   i_wheel_speed_1 = '0;
    t_speed                   i_wheel_speed_2 = '0;
    t_speed                   i_wheel_speed_3 = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    t_speed                   o_reference_speed_out;
    logic                     o_control_active;
    logic [1:0]               o_brake_cmd_0;
    logic [1:0]               o_brake_cmd_1;
    logic [1:0]               o_brake_cmd_2;
    logic [1:0]               o_brake_cmd_3;
    logic                     o_any_release;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int fail_count;
    int pending_count;

    abs_slip_controller DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_wheel_speed_0       (i_wheel_speed_0),
        .i_wheel_speed_1       (i_wheel_speed_1),
        .i_wheel_speed_2       (i_wheel_speed_2),
        .i_wheel_speed_3       (i_wheel_speed_3),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_reference_speed_out (o_reference_speed_out),
        .o_control_active      (o_control_active),
        .o_brake_cmd_0         (o_brake_cmd_0),
        .o_brake_cmd_1         (o_brake_cmd_1),
        .o_brake_cmd_2         (o_brake_cmd_2),
        .o_brake_cmd_3         (o_brake_cmd_3),
        .o_any_release         (o_any_release)
    );

    asc_checker u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .i_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_valid),
        .i_in_stall            (o_stall),
        .i_wheel_speed_0       (i_wheel_speed_0),
        .i_wheel_speed_1       (i_wheel_speed_1),
        .i_wheel_speed_2       (i_wheel_speed_2),
        .i_wheel_speed_3       (i_wheel_speed_3),
        .i_out_valid           (o_valid),
        .i_out_stall           (i_stall),
        .i_reference_speed_out (o_reference_speed_out),
        .i_control_active      (o_control_active),
        .i_brake_cmd_0         (o_brake_cmd_0),
        .i_brake_cmd_1         (o_brake_cmd_1),
        .i_brake_cmd_2         (o_brake_cmd_2),
        .i_brake_cmd_3         (o_brake_cmd_3),
        .i_any_release         (o_any_release),
        .o_errors              (fail_count),
        .o_pending             (pending_count)
    );

    // 2 ns clock period
    always #1 i_clk = ~i_clk;

    // Receiver back-pressure: redraw the stall every cycle at the phase's rate
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Watchdog: any transaction on any channel counts as progress
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one set of wheel speeds and hold it until the transaction completes.
    // An idle gap, if drawn, lowers valid first; otherwise valid stays high so
    // back-to-back transactions never drop it within one time step.
    task automatic push_wheels(input t_speed s0, s1, s2, s3);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_wheel_speed_0 <= s0;
        i_wheel_speed_1 <= s1;
        i_wheel_speed_2 <= s2;
        i_wheel_speed_3 <= s3;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Write one register; the channel drops for a cycle after each write
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted result has been taken.
    // The first edge lets the checker's count catch up with the last transaction.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Speed-sized register value, biased towards the extremes and low speeds
    function automatic logic [CFG_DATA_BITS-1:0] pick_speed();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 600));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Threshold write: random upper byte, which the block must discard
    function automatic logic [CFG_DATA_BITS-1:0] pick_thr();
        logic [7:0] thr;
        case ($urandom_range(0, 4))
            0:       thr = 8'd0;
            1:       thr = 8'd255;
            default: thr = 8'($urandom_range(0, 120));
        endcase
        return {8'($urandom_range(0, 255)), thr};
    endfunction

    initial begin
        t_speed      wheel[NUM_WHEELS];
        int unsigned cruise;
        int          kind;
        int          slip;
        cruise = 16'h4000;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: reset settings (release 51, apply 26, drop 23, min 256)
        push_wheels(16'd0, 16'd0, 16'd0, 16'd0);          // zero reference, inactive
        push_wheels(16'd255, 16'd0, 16'd17, 16'd3);       // one below minimum speed
        push_wheels(16'd256, 16'd0, 16'd0, 16'd256);      // exactly at minimum speed
        // reference 4096: release boundary holds, one past it releases,
        // apply boundary holds
        push_wheels(16'd4096, 16'd3280, 16'd3279, 16'd3680);
        // one inside the apply boundary applies; a stopped wheel releases
        push_wheels(16'd4096, 16'd3681, 16'd3680, 16'd0);
        push_wheels(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_wheels(16'd0, 16'd0, 16'd0, 16'd0);          // decay from full scale
        push_wheels(16'hFFFF, 16'd0, 16'hAAAA, 16'h5555);
        push_wheels(16'd0, 16'd0, 16'd0, 16'd0);
        drain_results();

        // ---- directed: apply threshold above release, instant decay, no minimum
        write_reg(CFG_HIGH_THR, 16'hA500);
        write_reg(CFG_LOW_THR, 16'h5AFF);
        write_reg(CFG_REF_DROP, 16'hFFFF);
        write_reg(CFG_MIN_SPD, 16'h0000);
        write_reg(CFG_INIT_REF, 16'h0000);
        // indexes past the register list must be ignored
        write_reg(3'd5, 16'($urandom_range(0, 65535)));
        write_reg(3'd6, 16'($urandom_range(0, 65535)));
        write_reg(3'd7, 16'($urandom_range(0, 65535)));
        push_wheels(16'd0, 16'd0, 16'd0, 16'd0);          // zero reference while active
        push_wheels(16'd100, 16'd50, 16'd0, 16'd100);
        push_wheels(16'd1, 16'd0, 16'd0, 16'd0);
        drain_results();

        // ---- directed: widest release threshold, no decay, full-scale minimum
        write_reg(CFG_REF_DROP, 16'h0000);
        write_reg(CFG_MIN_SPD, 16'hFFFF);
        write_reg(CFG_INIT_REF, 16'hFFFF);
        write_reg(CFG_HIGH_THR, 16'h00FF);
        write_reg(CFG_LOW_THR, 16'hFF00);
        push_wheels(16'd0, 16'd0, 16'd0, 16'd0);
        push_wheels(16'hFFFF, 16'hFFFE, 16'h8000, 16'd1);
        push_wheels(16'd0, 16'd0, 16'd0, 16'd0);
        drain_results();

        // ---- directed: preloaded reference decaying by one per step
        write_reg(CFG_INIT_REF, 16'h1234);
        write_reg(CFG_MIN_SPD, 16'h0100);
        write_reg(CFG_REF_DROP, 16'h0001);
        push_wheels(16'd0, 16'd0, 16'd0, 16'd0);
        push_wheels(16'h1233, 16'h1000, 16'h0800, 16'h1200);

        // ---- random phases: fresh settings and idling pattern for each
        for (int p = 0; p < PHASE_COUNT; p++) begin
            // hold the sender until the block is empty before reconfiguring
            drain_results();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            write_reg(CFG_HIGH_THR, pick_thr());
            write_reg(CFG_LOW_THR, pick_thr());
            write_reg(CFG_REF_DROP, pick_speed());
            write_reg(CFG_MIN_SPD, pick_speed());
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_INIT_REF, pick_speed());

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // advance a notional vehicle: mostly braking, now and then a jump
                if ($urandom_range(0, 39) == 0 || cruise < 64)
                    cruise = $urandom_range(0, 65535);
                else
                    cruise = cruise - $urandom_range(0, 40);
                kind = $urandom_range(0, 9);
                for (int j = 0; j < NUM_WHEELS; j++) begin
                    case (kind)
                        0: wheel[j] = t_speed'($urandom_range(0, 65535));
                        1: wheel[j] = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'h0000;
                        default: begin
                            // wheel lagging the vehicle by a random slip fraction
                            slip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 80);
                            wheel[j] = t_speed'(cruise - ((cruise * slip) >> 8));
                        end
                    endcase
                end
                push_wheels(wheel[0], wheel[1], wheel[2], wheel[3]);
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/asc_pkg.sv
hw/rtl/asc_ref_tracker.sv
hw/rtl/asc_slip_lane.sv
hw/rtl/asc_result_merge.sv
hw/rtl/abs_slip_controller.sv
bench/asc_checker.sv
bench/tb.sv
